### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the text console cursor engine modules.
// Every macro samples on the rising edge of clk and is disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// A condition that must imply another in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### sv/tcce_pkg.sv
// ---------------------------------------------------------------------------
// tcce_pkg
// Screen geometry, field widths, character codes and the controller to
// datapath interface types of the text console cursor engine.
// ---------------------------------------------------------------------------
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int IDX_W  = 11;
  localparam int CODE_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = ATTR_W + CODE_W;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int LIN_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  localparam int TAB_STEP = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic [CODE_W-1:0] CH_BS    = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CODE_W-1:0] CH_LF    = 8'd10;
  localparam logic [CODE_W-1:0] CH_FF    = 8'd12;
  localparam logic [CODE_W-1:0] CH_CR    = 8'd13;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CODE_W-1:0] CH_TILDE = 8'd126;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec_put;
    logic rd_en;
    logic fill_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic fill_needed;
    logic fill_done;
  } dp_status_t;

  // Linear cell index of a screen position.
  function automatic logic [LIN_W-1:0] lin_addr(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
  endfunction

endpackage

### sv/tcce_ctrl.sv
// ---------------------------------------------------------------------------
// tcce_ctrl
// Sequencer of the cursor engine: power-up clear, item execution, line or
// screen blanking sweeps and the result strobe.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  tcce_pkg::dp_status_t  status,
  output tcce_pkg::dp_cmd_t     cmd
);
  import tcce_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.fill_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!status.is_read && status.fill_needed) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        if (status.fill_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
      end
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.rd_en    = status.is_read;
        cmd.exec_put = !status.is_read;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.load, cmd.exec_put, cmd.rd_en, cmd.fill_step, cmd.out_load}), "controller issued two datapath commands at once")
  `ASSERT_NEXT(a_read_then_result, cmd.rd_en, cmd.out_load, "read did not complete in the following cycle")

endmodule

### sv/tcce_datapath.sv
// ---------------------------------------------------------------------------
// tcce_datapath
// Screen memory, cursor registers, next-cursor logic, blanking address
// sweep and the registered result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           operation,
  input  logic [tcce_pkg::CODE_W-1:0]    char_code,
  input  logic [tcce_pkg::IDX_W-1:0]     read_index,
  input  logic                           attr_we,
  input  logic [tcce_pkg::ATTR_W-1:0]    attr_data,
  input  tcce_pkg::dp_cmd_t              cmd,
  output tcce_pkg::dp_status_t           status,
  output logic                           result_valid,
  output logic [tcce_pkg::ROW_W-1:0]     cursor_row,
  output logic [tcce_pkg::COL_W-1:0]     cursor_column,
  output logic [tcce_pkg::POS_W-1:0]     cursor_position,
  output logic [tcce_pkg::CELL_W-1:0]    cell_value
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic              op_q;
  logic [CODE_W-1:0] code_q;
  logic [IDX_W-1:0]  idx_q;

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  prev_row;
  logic [ATTR_W-1:0] attr;

  logic [ADDR_W-1:0] fill_addr;
  logic [ADDR_W-1:0] fill_last;
  logic [CELL_W-1:0] fill_value;
  logic [CELL_W-1:0] rdata;

  logic [COL_W:0]    col_adv;
  logic [ROW_W:0]    row_adv;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic              printable;
  logic              is_ff;
  logic              row_change;
  logic              in_range;
  logic              fill_done;

  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;

  // Cursor movement for the latched byte, then column and row wrap.
  always_comb begin
    printable = code_q inside {[CH_SPACE:CH_TILDE]};
    col_adv   = {1'b0, col};
    row_adv   = {1'b0, row};
    if (printable) begin
      col_adv = col_adv + (COL_W+1)'(1);
    end else begin
      case (code_q)
        CH_BS: begin
          if (col != '0) begin
            col_adv = col_adv - (COL_W+1)'(1);
          end
        end
        CH_TAB: begin
          col_adv = col_adv + (COL_W+1)'(TAB_STEP);
        end
        CH_LF: begin
          row_adv = row_adv + (ROW_W+1)'(1);
          col_adv = '0;
        end
        CH_CR: begin
          col_adv = '0;
        end
        default: begin
          col_adv = {1'b0, col};
        end
      endcase
    end
    if (col_adv >= (COL_W+1)'(COLUMNS)) begin
      col_adv = '0;
      row_adv = row_adv + (ROW_W+1)'(1);
    end
    if (row_adv >= (ROW_W+1)'(ROWS)) begin
      row_adv = '0;
    end
    row_next = row_adv[ROW_W-1:0];
    col_next = col_adv[COL_W-1:0];
  end

  assign is_ff      = (code_q == CH_FF);
  assign row_change = (row_next != prev_row);
  assign in_range   = (32'(idx_q) < 32'(CELL_COUNT));
  assign fill_done  = (fill_addr == fill_last);

  assign status.is_read     = (op_q == OP_READ);
  assign status.fill_needed = is_ff || row_change;
  assign status.fill_done   = fill_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      code_q <= char_code;
      idx_q  <= read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      col        <= '0;
      prev_row   <= '0;
      attr       <= ATTR_RESET;
      fill_addr  <= '0;
      fill_last  <= ADDR_W'(CELL_COUNT - 1);
      fill_value <= {ATTR_RESET, CH_SPACE};
    end else begin
      if (attr_we) begin
        attr <= attr_data;
      end
      if (cmd.exec_put) begin
        if (is_ff) begin
          row        <= '0;
          col        <= '0;
          prev_row   <= '0;
          fill_addr  <= '0;
          fill_last  <= ADDR_W'(CELL_COUNT - 1);
          fill_value <= {attr, CH_SPACE};
        end else begin
          row <= row_next;
          col <= col_next;
          if (row_change) begin
            prev_row   <= row_next;
            fill_addr  <= ADDR_W'(lin_addr(row_next, '0));
            fill_last  <= ADDR_W'(lin_addr(row_next, COL_W'(COLUMNS - 1)));
            fill_value <= {attr, CH_SPACE};
          end
        end
      end else if (cmd.fill_step && !fill_done) begin
        fill_addr <= fill_addr + ADDR_W'(1);
      end
    end
  end

  // One write port shared by the character store and the blanking sweep.
  always_comb begin
    mem_we = (cmd.exec_put && printable) || cmd.fill_step;
    waddr  = cmd.fill_step ? fill_addr : ADDR_W'(lin_addr(row, col));
    wdata  = cmd.fill_step ? fill_value : {attr, code_q};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[ADDR_W'(idx_q)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_row      <= row;
      cursor_column   <= col;
      cursor_position <= POS_W'(lin_addr(row, col));
      cell_value      <= (status.is_read && in_range) ? rdata : '0;
    end
  end

  `ASSERT_ALWAYS(a_cursor_on_screen, (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLUMNS)), "cursor left the screen")
  `ASSERT_ALWAYS(a_line_record, prev_row == row, "last-line record out of step with cursor row")
  `ASSERT_NEXT(a_single_strobe, result_valid, !result_valid, "result strobe held for two cycles")

endmodule

### sv/text_console_cursor_engine_unit.sv
// ---------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Text console cursor engine: a screen of attribute/character cells with a
// cursor that prints, moves, wraps and blanks lines, plus a cell read.
// ---------------------------------------------------------------------------
//
//   Channel   | Handshake                     | Payload
//   ----------+-------------------------------+---------------------------------
//   item in   | start, busy (taken: start &   | operation, char_code, read_index
//             | !busy)                        |
//   result    | result_valid (one cycle)      | cursor_row, cursor_column,
//             |                               | cursor_position, cell_value
//   attribute | text_attribute_we             | text_attribute_data
//
// A read or a put that stays on its line passes through the execute and
// done states; the result strobe shows in the same cycle that busy drops.
// A put that enters a new line adds a line blanking sweep, and a form feed
// adds a screen sweep; both sweeps are paced by the single write port of the
// screen memory. After reset the screen is cleared in a pass with busy
// high; attribute writes are taken during that pass.
// Results cannot be stalled: each is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module text_console_cursor_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [tcce_pkg::CODE_W-1:0]   char_code,
  input  logic [tcce_pkg::IDX_W-1:0]    read_index,
  input  logic                          text_attribute_we,
  input  logic [tcce_pkg::ATTR_W-1:0]   text_attribute_data,
  output logic                          result_valid,
  output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcce_pkg::COL_W-1:0]    cursor_column,
  output logic [tcce_pkg::POS_W-1:0]    cursor_position,
  output logic [tcce_pkg::CELL_W-1:0]   cell_value
);
  import tcce_pkg::*;

  // Commands from the sequencer and the datapath status it watches.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The sequencer walks each item through execute, an optional blanking
  // sweep, and the result cycle. It also owns the power-up clear, which it
  // runs as a sweep over the whole screen before the first item is taken.
  tcce_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // The datapath holds the screen memory, the cursor and the attribute
  // register. Inputs are latched on acceptance so the ports are free while
  // the item is at work.
  tcce_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .operation       (operation),
    .char_code       (char_code),
    .read_index      (read_index),
    .attr_we         (text_attribute_we),
    .attr_data       (text_attribute_data),
    .cmd             (cmd),
    .status          (status),
    .result_valid    (result_valid),
    .cursor_row      (cursor_row),
    .cursor_column   (cursor_column),
    .cursor_position (cursor_position),
    .cell_value      (cell_value)
  );

endmodule

### dv/console_tracker_pkg.sv
// ---------------------------------------------------------------------------
// console_tracker_pkg
// Mirror of the text screen and cursor that predicts each cursor report
// and compares it with what the console engine sends.
// ---------------------------------------------------------------------------
package console_tracker_pkg;

  import tcce_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_word;
  } cursor_report_t;

  class console_cursor_tracker;

    logic [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned       cur_row;
    int unsigned       cur_col;
    int unsigned       prev_line;
    logic [ATTR_W-1:0] attr;
    cursor_report_t    reports_due [$];
    int unsigned       failures;

    function new();
      attr      = ATTR_RESET;
      cur_row   = 0;
      cur_col   = 0;
      prev_line = 0;
      failures  = 0;
      blank_cells(0, CELL_COUNT);
    endfunction

    function void blank_cells(int unsigned first, int unsigned count);
      for (int unsigned i = first; i < first + count; i++) cells[i] = {attr, CH_SPACE};
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    // One put byte: print or move, then wrap the cursor and blank a newly
    // entered line; a form feed blanks the whole screen and homes the cursor.
    function void print_byte(logic [CODE_W-1:0] code);
      if (code >= CH_SPACE && code <= CH_TILDE) begin
        if (cur_row * COLUMNS + cur_col < CELL_COUNT)
          cells[cur_row * COLUMNS + cur_col] = {attr, code};
        cur_col++;
      end else if (code == CH_BS) begin
        if (cur_col > 0) cur_col--;
      end else if (code == CH_TAB) begin
        cur_col += TAB_STEP;
      end else if (code == CH_LF) begin
        cur_row++;
        cur_col = 0;
      end else if (code == CH_FF) begin
        blank_cells(0, CELL_COUNT);
        cur_row   = 0;
        cur_col   = 0;
        prev_line = 0;
        return;
      end else if (code == CH_CR) begin
        cur_col = 0;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) cur_row = 0;
      if (cur_row != prev_line) begin
        blank_cells(cur_row * COLUMNS, COLUMNS);
        prev_line = cur_row;
      end
    endfunction

    function void note_item(logic op, logic [CODE_W-1:0] code, logic [IDX_W-1:0] idx);
      cursor_report_t r;
      r.cell_word = '0;
      if (op == OP_PUT) print_byte(code);
      else if (idx < CELL_COUNT) r.cell_word = cells[idx];
      r.row = ROW_W'(cur_row);
      r.col = COL_W'(cur_col);
      r.pos = POS_W'(cur_row * COLUMNS + cur_col);
      reports_due.push_back(r);
    endfunction

    // Every mismatch gets one line in the log and is counted.
    task mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      failures++;
    endtask

    task check_report(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                      logic [POS_W-1:0] pos, logic [CELL_W-1:0] cell_word);
      cursor_report_t want;
      if (reports_due.size() == 0) begin
        mismatch($sformatf("unexpected result row %0d col %0d", row, col));
        return;
      end
      want = reports_due.pop_front();
      if (row !== want.row)
        mismatch($sformatf("cursor_row %0d, expected %0d", row, want.row));
      if (col !== want.col)
        mismatch($sformatf("cursor_column %0d, expected %0d", col, want.col));
      if (pos !== want.pos)
        mismatch($sformatf("cursor_position %0d, expected %0d", pos, want.pos));
      if (cell_word !== want.cell_word)
        mismatch($sformatf("cell_value %h, expected %h", cell_word, want.cell_word));
    endtask

  endclass

endpackage

### dv/text_console_cursor_engine_unit_test.sv
// ---------------------------------------------------------------------------
// text_console_cursor_engine_unit_test
// Drives put and read items into the console engine with random pacing,
// changes the text attribute between phases, and checks every cursor
// report against a mirrored screen and cursor.
// ---------------------------------------------------------------------------
module text_console_cursor_engine_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;
  import console_tracker_pkg::*;

  // The slowest legal gap between two handshakes is a form feed sweep, or
  // the clearing pass after reset; this leaves ample margin.
  localparam int unsigned QUIET_LIMIT = 20000;
  // Number of counted random items in each attribute phase.
  localparam int unsigned PHASE_ITEMS = 188;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              operation;
  logic [CODE_W-1:0] char_code;
  logic [IDX_W-1:0]  read_index;
  logic              text_attribute_we;
  logic [ATTR_W-1:0] text_attribute_data;
  logic              result_valid;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_column;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_value;

  console_cursor_tracker tracker;
  int unsigned           items_counted;
  int unsigned           quiet_cycles;

  text_console_cursor_engine_unit u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .operation           (operation),
    .char_code           (char_code),
    .read_index          (read_index),
    .text_attribute_we   (text_attribute_we),
    .text_attribute_data (text_attribute_data),
    .result_valid        (result_valid),
    .cursor_row          (cursor_row),
    .cursor_column       (cursor_column),
    .cursor_position     (cursor_position),
    .cell_value          (cell_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Results are shown for a single cycle and cannot be held off, so every
  // strobe seen at a rising edge is checked right away.
  always @(posedge clk) begin
    if (!rst && result_valid)
      tracker.check_report(cursor_row, cursor_column, cursor_position, cell_value);
  end

  // The watchdog restarts whenever an item is taken or a result shows up.
  // A block that stops answering trips it and ends the run as a failure.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Lowers start for the pause that the caller asks for. The random length lets the next item
  // land at any point of the block's own work on the previous one.
  task pause_sender(int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Presents one item at a falling edge and holds it until a rising edge
  // finds busy low. Start stays high from one item to the next unless a
  // pause is taken, so it never gets two assignments in one step.
  task send_item(logic op, logic [CODE_W-1:0] code, logic [IDX_W-1:0] idx);
    @(negedge clk);
    start      <= 1'b1;
    operation  <= op;
    char_code  <= code;
    read_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_item(op, code, idx);
    // Bytes that the block only ignores do not count toward the item total.
    if (op == OP_READ || (code >= CH_SPACE && code <= CH_TILDE) ||
        code inside {CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR})
      items_counted++;
    // A stretch in the middle of the run goes without any pauses.
    if (!(items_counted >= 250 && items_counted < 420) && $urandom_range(0, 99) < 30)
      pause_sender($urandom_range(1, 7));
  endtask

  // The attribute is only changed once the block has answered everything.
  task write_attribute(logic [ATTR_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (tracker.reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    text_attribute_we   <= 1'b1;
    text_attribute_data <= value;
    @(negedge clk);
    text_attribute_we   <= 1'b0;
    tracker.set_attribute(value);
  endtask

  // One random burst. Most bursts are text that a program would really
  // print: runs of characters, whole lines, line feeds that walk the cursor
  // down and around the screen, cursor moves and reads, often near the cursor. The
  // rest is noise from the whole byte range and the occasional screen clear.
  task run_burst();
    int unsigned       kind;
    int unsigned       here;
    logic [IDX_W-1:0]  idx;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      repeat ($urandom_range(1, 90))
        send_item(OP_PUT, CODE_W'($urandom_range(32, 126)), IDX_W'($urandom));
    end else if (kind < 50) begin
      repeat ($urandom_range(1, 30)) send_item(OP_PUT, CH_LF, IDX_W'($urandom));
    end else if (kind < 60) begin
      // Cursor moves only: backspace, tab and carriage return mixed.
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 2))
          0: send_item(OP_PUT, CH_BS, IDX_W'($urandom));
          1: send_item(OP_PUT, CH_TAB, IDX_W'($urandom));
          default: send_item(OP_PUT, CH_CR, IDX_W'($urandom));
        endcase
      end
    end else if (kind < 75) begin
      repeat ($urandom_range(1, 6)) begin
        here = tracker.cur_row * COLUMNS + tracker.cur_col;
        if ($urandom_range(0, 9) == 0)
          idx = IDX_W'($urandom_range(CELL_COUNT, (1 << IDX_W) - 1));
        else if ($urandom_range(0, 1) == 0)
          idx = IDX_W'(here - (here < 6 ? here : $urandom_range(0, 6)));
        else
          idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
        send_item(OP_READ, CODE_W'($urandom), idx);
      end
    end else if (kind < 82) begin
      repeat ($urandom_range(1, 5))
        send_item(1'($urandom), CODE_W'($urandom), IDX_W'($urandom));
    end else if (kind < 86) begin
      send_item(OP_PUT, CH_FF, IDX_W'($urandom));
    end else begin
      // A typed line ended by carriage return and line feed.
      repeat ($urandom_range(0, 79))
        send_item(OP_PUT, CODE_W'($urandom_range(32, 126)), IDX_W'($urandom));
      send_item(OP_PUT, CH_CR, IDX_W'($urandom));
      send_item(OP_PUT, CH_LF, IDX_W'($urandom));
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] phase_attr [4];
    tracker             = new();
    items_counted       = 0;
    rst                 = 1'b1;
    start               = 1'b0;
    operation           = OP_PUT;
    char_code           = '0;
    read_index          = '0;
    text_attribute_we   = 1'b0;
    text_attribute_data = '0;
    phase_attr[0]       = 8'h00;
    phase_attr[1]       = 8'hFF;
    phase_attr[2]       = ATTR_W'($urandom_range(1, 254));
    phase_attr[3]       = ATTR_RESET;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The block clears its screen after reset with busy high.
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // Directed items under the reset attribute. Reads first see the blank
    // screen, including the last cell and an index past the screen with
    // every bit set. Then the printable limits, ignored bytes from both
    // sides of the printable range, each control byte, backspace at column
    // 0, a line entry, and a screen clear followed by a printed character
    // that must survive.
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_READ, 8'h00, 11'd1999);
    send_item(OP_READ, 8'hFF, 11'h7FF);
    send_item(OP_PUT, 8'd65, 11'd0);
    send_item(OP_PUT, CH_SPACE, 11'd0);
    send_item(OP_PUT, CH_TILDE, 11'd0);
    send_item(OP_PUT, 8'd0, 11'd0);
    send_item(OP_PUT, 8'd31, 11'd0);
    send_item(OP_PUT, 8'd127, 11'd0);
    send_item(OP_PUT, 8'd128, 11'd0);
    send_item(OP_PUT, 8'hFF, 11'h7FF);
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_READ, 8'h00, 11'd2);
    send_item(OP_PUT, CH_BS, 11'd0);
    send_item(OP_PUT, CH_CR, 11'd0);
    send_item(OP_PUT, CH_BS, 11'd0);
    send_item(OP_PUT, CH_TAB, 11'd0);
    send_item(OP_PUT, 8'd11, 11'd0);
    send_item(OP_PUT, CH_LF, 11'd0);
    send_item(OP_READ, 8'h00, 11'd80);
    send_item(OP_PUT, CH_FF, 11'd0);
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_PUT, 8'd90, 11'd0);
    send_item(OP_READ, 8'h00, 11'd0);

    // Random phases, each under its own attribute: both extremes, a random value
    // in between and finally the reset value written back explicitly.
    items_counted = 0;
    for (int p = 0; p < 4; p++) begin
      write_attribute(phase_attr[p]);
      while (items_counted < (p + 1) * PHASE_ITEMS) run_burst();
    end

    @(negedge clk);
    start <= 1'b0;
    while (tracker.reports_due.size() != 0) @(posedge clk);
    // Wait on to catch any stray result strobe.
    repeat (50) @(posedge clk);
    if (tracker.reports_due.size() != 0)
      tracker.mismatch("results still expected at the end of the run");

    if (tracker.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
